FILE: rtl/core/cwlr_pkg.sv
// cwlr_pkg: shared types and constants of the clipped wide-line rasterizer
// used by the channel interfaces and the rasterizer top level
`default_nettype none
package cwlr_pkg;
	localparam int LAYER_W_DEF = 320;
	localparam int LAYER_H_DEF = 480;
	localparam int FRAC_BITS   = 8;
	localparam logic [10:0] PITCH_RESET = 11'd320;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef logic signed [15:0] in_coord_t;
	typedef logic signed [17:0] coord_t;
	typedef logic [10:0] pitch_t;
	typedef logic [18:0] addr_t;
	typedef logic [6:0]  width_t;
	typedef logic [7:0]  color_t;
endpackage
`default_nettype wire

FILE: rtl/core/cwlr_if.sv
// cwlr channel interfaces: command request, span result and pitch write
// depends on cwlr_pkg
`default_nettype none
interface cwlr_cmd_if;
	logic                valid;
	logic                ready;
	logic                command;
	cwlr_pkg::in_coord_t start_x;
	cwlr_pkg::in_coord_t start_y;
	cwlr_pkg::in_coord_t end_x;
	cwlr_pkg::in_coord_t end_y;
	cwlr_pkg::color_t    pixel_color;
	cwlr_pkg::width_t    line_width;
	modport source (output valid, command, start_x, start_y, end_x, end_y, pixel_color,
		line_width, input ready);
	modport sink (input valid, command, start_x, start_y, end_x, end_y, pixel_color,
		line_width, output ready);
endinterface

interface cwlr_span_if;
	logic             valid;
	logic             ready;
	cwlr_pkg::addr_t  span_address;
	cwlr_pkg::width_t span_length;
	logic             span_vertical;
	cwlr_pkg::color_t span_color;
	logic             span_last;
	modport source (output valid, span_address, span_length, span_vertical, span_color,
		span_last, input ready);
	modport sink (input valid, span_address, span_length, span_vertical, span_color,
		span_last, output ready);
endinterface

interface cwlr_cfg_if;
	logic             valid;
	logic             ready;
	cwlr_pkg::pitch_t line_pitch;
	modport source (output valid, line_pitch, input ready);
	modport sink (input valid, line_pitch, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/clipped_wide_line_rasterizer.sv
// clipped_wide_line_rasterizer: wide-line clipper and fixed-point dda span generator
// depends on cwlr_pkg and the channel interfaces in cwlr_if.sv
//
// Usage: a start request (command 0) carries two endpoints, a color and a width.
// The block offsets the endpoints by half the width, clips them against the layer
// one edge at a time and loads a dda. Each step request (command 1) returns one
// span on the span channel; a step with no line active returns nothing.
// After it is accepted, a start request keeps the block busy: an offset step,
// then every clip edge that cuts and the final slope go through one shared
// multiplier and a 38-bit restoring divider, one quotient bit a cycle; an edge
// that does not cut moves on without the divider. cmd.ready is low while busy.
// A step request is accepted whenever the block is idle and the span output
// register is empty or being drained, so spans stream one per cycle while the
// receiver takes them, each in the output register in the cycle after its request.
// If the receiver stalls, the span stays in its output register and cmd.ready
// drops until it is taken. The pitch register is written on cfg at any time
// (cfg.ready is always high) and should only change while the block is idle.
// After reset: no line is active, pitch is 320, width 1, color 0.
`default_nettype none
module clipped_wide_line_rasterizer #(
	parameter int LAYER_W = cwlr_pkg::LAYER_W_DEF,
	parameter int LAYER_H = cwlr_pkg::LAYER_H_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cwlr_cmd_if.sink   cmd,
	cwlr_cfg_if.sink   cfg,
	cwlr_span_if.source span
);
	import cwlr_pkg::*;

	localparam int DIV_W = 38;
	localparam int CNT_W = $clog2(DIV_W);
	localparam coord_t XM_BASE = coord_t'(LAYER_W - 1);
	localparam coord_t YM_BASE = coord_t'(LAYER_H - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_OFFS, ST_EDGE, ST_MUL, ST_DINIT, ST_DIV, ST_WB, ST_SLOPE
	} state_t;

	state_t state_q;
	pitch_t pitch_q;
	coord_t x1_q, y1_q, x2_q, y2_q;
	width_t w_q;
	color_t color_q;
	logic [1:0] edge_q;
	logic tgt_q, slope_q;
	logic signed [18:0] op_a_q, op_b_q, den_q;
	coord_t add_q;
	logic signed [37:0] prod_q;
	logic [DIV_W-1:0] mag_q;
	logic [19:0] rem_q;
	logic [18:0] dmag_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;

	logic [9:0] steps_q;
	logic majx_q, dir_q;
	logic signed [19:0] minor_pos_q;
	logic [10:0] major_pos_q;
	logic signed [17:0] minor_inc_q;

	logic out_valid_q;
	addr_t out_addr_q;
	width_t out_len_q;
	logic out_vert_q, out_last_q;
	color_t out_color_q;

	// combinational helpers
	logic cmd_acc, out_load, out_free;
	width_t w_in;
	logic signed [18:0] dx, dy, c1, c2, pq, o1, o2;
	logic [18:0] adx, ady;
	logic axis, out1, out2;
	coord_t bnd, xm, ym;
	logic [19:0] rem_sh;
	logic signed [37:0] qs;
	logic [11:0] minor_int, row, col;
	logic [22:0] addr_full;

	function automatic logic [18:0] abs19(input logic signed [18:0] v);
		return v[18] ? 19'(-v) : 19'(v);
	endfunction

	assign out_free = !out_valid_q || span.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cfg.ready = 1'b1;
	assign cmd_acc = cmd.valid && cmd.ready;
	assign out_load = cmd_acc && (cmd.command == CMD_STEP) && (steps_q != 10'd0);

	always_comb begin
		if (cmd.line_width == 7'd0) begin
			w_in = 7'd1;
		end else if (cmd.line_width > 7'd64) begin
			w_in = 7'd64;
		end else begin
			w_in = cmd.line_width;
		end
	end

	assign dx = 19'(x2_q) - 19'(x1_q);
	assign dy = 19'(y2_q) - 19'(y1_q);
	assign adx = abs19(dx);
	assign ady = abs19(dy);
	assign xm = XM_BASE - coord_t'(w_q);
	assign ym = YM_BASE - coord_t'(w_q);

	// edge setup: axis 0 is x, odd edges are the upper bounds
	assign axis = edge_q[1];
	assign bnd = edge_q[0] ? (axis ? ym : xm) : coord_t'(0);
	assign c1 = 19'(axis ? y1_q : x1_q) - 19'(bnd);
	assign c2 = 19'(axis ? y2_q : x2_q) - 19'(bnd);
	assign pq = c2 - c1;
	assign o1 = 19'(axis ? x1_q : y1_q);
	assign o2 = 19'(axis ? x2_q : y2_q);
	assign out1 = edge_q[0] ? (c1 > 19'sd0) : c1[18];
	assign out2 = edge_q[0] ? (c2 > 19'sd0) : c2[18];

	assign rem_sh = {rem_q[18:0], mag_q[DIV_W-1]};
	assign qs = (den_q == 19'sd0) ? 38'sd0 : (neg_q ? -$signed(mag_q) : $signed(mag_q));

	assign minor_int = minor_pos_q[19] ? 12'd0 : minor_pos_q[19:8];
	assign row = majx_q ? minor_int : {1'b0, major_pos_q};
	assign col = majx_q ? {1'b0, major_pos_q} : minor_int;
	assign addr_full = 23'(row) * 23'(pitch_q) + 23'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			pitch_q <= cfg.line_pitch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			steps_q <= 10'd0;
			majx_q <= 1'b0;
			dir_q <= 1'b0;
			minor_pos_q <= '0;
			major_pos_q <= '0;
			minor_inc_q <= '0;
			color_q <= '0;
			w_q <= 7'd1;
			out_valid_q <= 1'b0;
			edge_q <= '0;
			slope_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.command == CMD_START) begin
						x1_q <= coord_t'(cmd.start_x);
						y1_q <= coord_t'(cmd.start_y);
						x2_q <= coord_t'(cmd.end_x);
						y2_q <= coord_t'(cmd.end_y);
						w_q <= w_in;
						color_q <= cmd.pixel_color;
						steps_q <= 10'd0;
						state_q <= ST_OFFS;
					end else if (out_load) begin
						out_addr_q <= addr_full[18:0];
						out_len_q <= w_q;
						out_vert_q <= majx_q;
						out_color_q <= color_q;
						out_last_q <= (steps_q == 10'd1);
						minor_pos_q <= minor_pos_q + 20'(minor_inc_q);
						major_pos_q <= dir_q ? major_pos_q - 11'd1 : major_pos_q + 11'd1;
						steps_q <= steps_q - 10'd1;
					end
				end
				ST_OFFS: begin
					if (adx < ady) begin
						x1_q <= x1_q - coord_t'(w_q[6:1]);
						x2_q <= x2_q - coord_t'(w_q[6:1]);
					end else begin
						y1_q <= y1_q - coord_t'(w_q[6:1]);
						y2_q <= y2_q - coord_t'(w_q[6:1]);
					end
					edge_q <= 2'd0;
					slope_q <= 1'b0;
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					if (out1 && out2) begin
						state_q <= ST_IDLE;
					end else if (out1 || out2) begin
						tgt_q <= !out1;
						op_a_q <= out1 ? o1 - o2 : o2 - o1;
						op_b_q <= out1 ? c2 : c1;
						den_q <= out1 ? pq : -pq;
						add_q <= out1 ? o2[17:0] : o1[17:0];
						// move the outside endpoint onto the edge
						if (out1) begin
							if (axis) y1_q <= bnd;
							else x1_q <= bnd;
						end else begin
							if (axis) y2_q <= bnd;
							else x2_q <= bnd;
						end
						state_q <= ST_MUL;
					end else if (edge_q == 2'd3) begin
						state_q <= ST_SLOPE;
					end else begin
						edge_q <= edge_q + 2'd1;
					end
				end
				ST_MUL: begin
					prod_q <= op_a_q * op_b_q;
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					mag_q <= prod_q[37] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
					neg_q <= prod_q[37] ^ den_q[18];
					dmag_q <= abs19(den_q);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, dmag_q}) begin
						rem_q <= rem_sh - {1'b0, dmag_q};
						mag_q <= {mag_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						mag_q <= {mag_q[DIV_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_W - 1)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (slope_q) begin
						minor_inc_q <= qs[17:0];
						steps_q <= den_q[9:0];
						state_q <= ST_IDLE;
					end else begin
						if (tgt_q) begin
							// the other axis of the endpoint moved onto the edge
							if (axis) x2_q <= qs[17:0] + add_q;
							else y2_q <= qs[17:0] + add_q;
						end else begin
							if (axis) x1_q <= qs[17:0] + add_q;
							else y1_q <= qs[17:0] + add_q;
						end
						if (edge_q == 2'd3) begin
							state_q <= ST_SLOPE;
						end else begin
							edge_q <= edge_q + 2'd1;
							state_q <= ST_EDGE;
						end
					end
				end
				ST_SLOPE: begin
					slope_q <= 1'b1;
					op_b_q <= 19'sd256;
					if (adx < ady) begin
						majx_q <= 1'b0;
						op_a_q <= dx;
						den_q <= $signed(ady);
						minor_pos_q <= {x1_q[11:0], 8'd0};
						major_pos_q <= y1_q[10:0];
						dir_q <= y2_q < y1_q;
					end else begin
						majx_q <= 1'b1;
						op_a_q <= dy;
						den_q <= (adx == 19'd0) ? 19'sd1 : $signed(adx);
						minor_pos_q <= {y1_q[11:0], 8'd0};
						major_pos_q <= x1_q[10:0];
						dir_q <= x2_q < x1_q;
					end
					state_q <= ST_MUL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign span.valid = out_valid_q;
	assign span.span_address = out_addr_q;
	assign span.span_length = out_len_q;
	assign span.span_vertical = out_vert_q;
	assign span.span_color = out_color_q;
	assign span.span_last = out_last_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.ready) else $error("request taken while busy");
	a_start_kills_line: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.command == CMD_START) |=> (steps_q == 10'd0))
		else $error("start left a line active");
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && steps_q == 10'd1) |=> (steps_q == 10'd0 && out_last_q))
		else $error("last span did not end the line");
endmodule
`default_nettype wire
